// ===== rtl/pi_controller_sampled_antiwindup_macros.svh =====
// ---------------------------------------------------------------------------
// pi controller assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef PI_CONTROLLER_SAMPLED_ANTIWINDUP_MACROS_SVH
`define PI_CONTROLLER_SAMPLED_ANTIWINDUP_MACROS_SVH

// same-cycle implication
`define PISA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pisa check failed: same-cycle implication");

// next-cycle implication
`define PISA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pisa check failed: next-cycle implication");

`endif

// ===== rtl/pisa_pkg.sv =====
// ---------------------------------------------------------------------------
// pisa_pkg
// widths, register codes and controller/datapath command types
// ---------------------------------------------------------------------------
package pisa_pkg;

  localparam int ERROR_WIDTH_DEF = 16;

  localparam int DELTA_W   = 16;
  localparam int KP_W      = 16;
  localparam int KI_W      = 16;
  localparam int LIMIT_W   = 31;
  localparam int PERIOD_W  = 16;
  localparam int INTEG_W   = 32;
  localparam int ELAPSED_W = 32;
  localparam int DRIVE_W   = 49;

  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP     = 2'd0,
    CFG_KI     = 2'd1,
    CFG_LIMIT  = 2'd2,
    CFG_PERIOD = 2'd3
  } cfg_idx_t;

  localparam logic [KP_W-1:0]     KP_RST     = 16'd77;
  localparam logic [KI_W-1:0]     KI_RST     = 16'd0;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 31'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;

  // ms to seconds
  localparam int DIVISOR   = 1000;
  localparam int REM_W     = $clog2(DIVISOR);
  localparam int DIV_RADIX = 4;

  // shared multiplier: elapsed (zero-extended) or gain by error or integral
  localparam int MUL_A_W = ELAPSED_W + 1;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    MUL_ELAPSED_ERR = 2'd0,
    MUL_KP_ERR      = 2'd1,
    MUL_KI_INTEG    = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     skip;
    logic     div_start;
    logic     div_step;
    logic     integ_upd;
    logic     drive_load;
    logic     drive_add;
    logic     out_load;
  } pisa_cmd_t;

  typedef struct packed {
    logic below_period;
    logic div_last;
    logic out_free;
  } pisa_stat_t;

endpackage

// ===== rtl/pisa_in_if.sv =====
// ---------------------------------------------------------------------------
// pisa_in_if
// error sample channel: valid/ready with error and elapsed milliseconds
// ---------------------------------------------------------------------------
interface pisa_in_if import pisa_pkg::*; #(
  parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
) ();

  logic                          valid;
  logic                          ready;
  logic signed [ERROR_WIDTH-1:0] error_sample;
  logic [DELTA_W-1:0]            delta_ms;

  modport source (output valid, error_sample, delta_ms, input ready);
  modport sink   (input valid, error_sample, delta_ms, output ready);

endinterface

// ===== rtl/pisa_out_if.sv =====
// ---------------------------------------------------------------------------
// pisa_out_if
// result channel: valid/ready with fired flag and drive value
// ---------------------------------------------------------------------------
interface pisa_out_if import pisa_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic                      fired;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, fired, drive, input ready);
  modport sink   (input valid, fired, drive, output ready);

endinterface

// ===== rtl/pisa_ctrl.sv =====
// ---------------------------------------------------------------------------
// pisa_ctrl
// sequencer: accept, period check, divide, integrate, drive sum, deliver
// ---------------------------------------------------------------------------
module pisa_ctrl import pisa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output pisa_cmd_t  cmd,
  input  pisa_stat_t stat
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_DIV_LOAD = 8'b0000_0100,
    S_DIV      = 8'b0000_1000,
    S_INTEG    = 8'b0001_0000,
    S_MUL_KI   = 8'b0010_0000,
    S_SUM      = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MUL_ELAPSED_ERR;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // product is formed either way; unused when the period is not reached
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ELAPSED_ERR;
        if (stat.below_period) begin
          cmd.skip   = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_DIV_LOAD;
        end
      end
      S_DIV_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_INTEG;
        end
      end
      S_INTEG: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_KP_ERR;
        state_next    = S_MUL_KI;
      end
      S_MUL_KI: begin
        cmd.drive_load = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = MUL_KI_INTEG;
        state_next     = S_SUM;
      end
      S_SUM: begin
        cmd.drive_add = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pisa_dp.sv =====
// ---------------------------------------------------------------------------
// pisa_dp
// config registers, elapsed timer, shared multiplier, radix-16 divide by
// 1000, clamped integral, drive accumulator and output register
// ---------------------------------------------------------------------------
module pisa_dp import pisa_pkg::*; #(
  parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [ERROR_WIDTH-1:0] in_error,
  input  logic [DELTA_W-1:0]            in_delta,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_fired,
  output logic signed [DRIVE_W-1:0]     out_drive,
  input  pisa_cmd_t                     cmd,
  output pisa_stat_t                    stat
);

  // |elapsed * error| stays below 2^(31+ERROR_WIDTH)
  localparam int MAG_W     = ELAPSED_W - 1 + ERROR_WIDTH;
  localparam int DIV_STEPS = (MAG_W + DIV_RADIX - 1) / DIV_RADIX;
  localparam int DIV_W     = DIV_STEPS * DIV_RADIX;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int SUM_W     = DIV_W + 2;
  localparam logic [REM_W:0]     DIVISOR_C = (REM_W + 1)'(DIVISOR);
  localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(DIV_STEPS - 1);

  logic [KP_W-1:0]     kp;
  logic [KI_W-1:0]     ki;
  logic [LIMIT_W-1:0]  limit;
  logic [PERIOD_W-1:0] period;

  logic signed [ERROR_WIDTH-1:0] err;
  logic [ELAPSED_W-1:0]          elapsed;
  logic [ELAPSED_W:0]            elapsed_sum;
  logic [ELAPSED_W-1:0]          elapsed_next;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_mag;

  logic [DIV_W-1:0] dq;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             q_neg;
  logic [DIV_W-1:0] dq_v;
  logic [REM_W-1:0] rem_v;
  logic [REM_W:0]   trial;

  logic signed [INTEG_W-1:0] integ;
  logic signed [SUM_W-1:0]   q_ext;
  logic signed [SUM_W-1:0]   q_s;
  logic signed [SUM_W-1:0]   integ_sum;
  logic signed [SUM_W-1:0]   lim_s;
  logic signed [SUM_W-1:0]   integ_clamped;

  logic signed [DRIVE_W-1:0] drive_acc;
  logic                      fired_r;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      kp     <= KP_RST;
      ki     <= KI_RST;
      limit  <= LIMIT_RST;
      period <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KP:     kp     <= cfg_data[KP_W-1:0];
        CFG_KI:     ki     <= cfg_data[KI_W-1:0];
        CFG_LIMIT:  limit  <= cfg_data[LIMIT_W-1:0];
        CFG_PERIOD: period <= cfg_data[PERIOD_W-1:0];
      endcase
    end
  end

  // saturating elapsed timer
  assign elapsed_sum  = {1'b0, elapsed} + (ELAPSED_W + 1)'(in_delta);
  assign elapsed_next = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (cmd.accept) begin
      elapsed <= elapsed_next;
    end else if (cmd.integ_upd) begin
      elapsed <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      err <= in_error;
    end
  end

  assign stat.below_period = (elapsed < ELAPSED_W'(period));

  // shared multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_ELAPSED_ERR: begin
        mul_a = $signed({1'b0, elapsed});
        mul_b = MUL_B_W'(err);
      end
      MUL_KP_ERR: begin
        mul_a = MUL_A_W'($signed(kp));
        mul_b = MUL_B_W'(err);
      end
      MUL_KI_INTEG: begin
        mul_a = MUL_A_W'($signed(ki));
        mul_b = MUL_B_W'(integ);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // divide |product| by 1000, four quotient bits per cycle
  assign prod_mag = prod[PROD_W-1] ? -prod : prod;

  always_comb begin
    dq_v  = dq;
    rem_v = rem;
    trial = '0;
    for (int k = 0; k < DIV_RADIX; k++) begin
      trial = {rem_v, dq_v[DIV_W-1]};
      dq_v  = {dq_v[DIV_W-2:0], 1'b0};
      if (trial >= DIVISOR_C) begin
        rem_v    = REM_W'(trial - DIVISOR_C);
        dq_v[0]  = 1'b1;
      end else begin
        rem_v = trial[REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq    <= prod_mag[DIV_W-1:0];
      rem   <= '0;
      cnt   <= '0;
      q_neg <= prod[PROD_W-1];
    end else if (cmd.div_step) begin
      dq  <= dq_v;
      rem <= rem_v;
      cnt <= cnt + 1'b1;
    end
  end

  assign stat.div_last = (cnt == CNT_LAST);

  // integral update with symmetric clamp; quotient truncates toward zero
  assign q_ext     = $signed({2'b00, dq});
  assign q_s       = q_neg ? -q_ext : q_ext;
  assign integ_sum = SUM_W'(integ) + q_s;
  assign lim_s     = $signed(SUM_W'(limit));

  always_comb begin
    priority if (integ_sum > lim_s) begin
      integ_clamped = lim_s;
    end else if (integ_sum < -lim_s) begin
      integ_clamped = -lim_s;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (cmd.integ_upd) begin
      integ <= integ_clamped[INTEG_W-1:0];
    end
  end

  // drive accumulator, modulo 2^49; the true sum always fits
  always_ff @(posedge clk) begin
    if (cmd.skip) begin
      drive_acc <= '0;
      fired_r   <= 1'b0;
    end else begin
      if (cmd.integ_upd) begin
        fired_r <= 1'b1;
      end
      if (cmd.drive_load) begin
        drive_acc <= prod[DRIVE_W-1:0];
      end else if (cmd.drive_add) begin
        drive_acc <= drive_acc + prod[DRIVE_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_fired <= fired_r;
      out_drive <= drive_acc;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/pi_controller_sampled_antiwindup.sv =====
// ---------------------------------------------------------------------------
// pi_controller_sampled_antiwindup
// sampled pi controller with clamped integral and saturating elapsed timer
// ---------------------------------------------------------------------------
// channel   dir  handshake      payload
// sample    in   valid/ready    error_sample, delta_ms
// result    out  valid/ready    fired, drive
// cfg       in   cfg_we         cfg_index, cfg_data
//
// an item below the sample period skips from the period check to the result register.
// a fired item passes the radix-16 divide by 1000 and the one shared 33x32 multiplier.
// one item at a time; the next sample transfers while a result waits.
// rst is synchronous: integral and timer clear, registers take reset values.
// ---------------------------------------------------------------------------
module pi_controller_sampled_antiwindup import pisa_pkg::*; #(
  parameter int ERROR_WIDTH = ERROR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  pisa_in_if.sink               sample,
  pisa_out_if.source            result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pisa_cmd_t  cmd;
  pisa_stat_t stat;

  pisa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  pisa_dp #(
    .ERROR_WIDTH (ERROR_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_error  (sample.error_sample),
    .in_delta  (sample.delta_ms),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_fired (result.fired),
    .out_drive (result.drive),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== rtl/pisa_chk.sv =====
// ---------------------------------------------------------------------------
// pisa_chk
// port-level checks on the pi controller, bound to the top level
// ---------------------------------------------------------------------------
`include "pi_controller_sampled_antiwindup_macros.svh"

module pisa_chk import pisa_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_fired,
  input logic [DRIVE_W-1:0] out_drive
);

  // reset empties the result register
  `PISA_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

  // one item in flight: no transfer on the cycle after a transfer
  `PISA_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // a result that did not fire carries zero drive
  `PISA_ASSERT_SAME(a_idle_drive_zero, clk, rst, out_valid && !out_fired,
                    out_drive == '0)

  // stalled result holds
  `PISA_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(out_fired) && $stable(out_drive))

endmodule

bind pi_controller_sampled_antiwindup pisa_chk u_pisa_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_fired (result.fired),
  .out_drive (result.drive)
);
